/* src/nsfc_pkg.sv */
package nsfc_pkg;

    localparam int LINE_LIMIT = 90;
    localparam int COUNT_W    = $clog2(LINE_LIMIT + 2);
    localparam int LEN_W      = 7;
    localparam int TYPE_W     = 3;
    localparam int OUT_W      = 1 + TYPE_W + LEN_W;
    localparam int OUT_BYTES  = (OUT_W + 7) / 8;
    localparam int TDATA_W    = OUT_BYTES * 8;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam logic [TYPE_W-1:0] TYPE_GGA     = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_RMC     = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_GSV     = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_GLL     = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_GSA     = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_VTG     = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 3'd6;

    localparam int NUM_TYPES = 6;

    typedef logic [7:0] char_t;
    typedef char_t [2:0] type_str_t;

    // characters held first-to-last at index 0..2
    localparam type_str_t KNOWN_TYPES [NUM_TYPES] = '{
        '{8'h41, 8'h47, 8'h47},   // GGA
        '{8'h43, 8'h4D, 8'h52},   // RMC
        '{8'h56, 8'h53, 8'h47},   // GSV
        '{8'h4C, 8'h4C, 8'h47},   // GLL
        '{8'h41, 8'h53, 8'h47},   // GSA
        '{8'h47, 8'h54, 8'h56}    // VTG
    };

    function automatic char_t hex_char(input logic [3:0] nib);
        char_t c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

/* src/nmea_sentence_framer_checker.sv */
// channel  dir  width  fields (lowest bit up)
// s_*      in   8      rx_byte
// m_*      out  16     checksum_ok, sentence_type[2:0], line_length[6:0], zero pad
//
// One word per cycle while the result is not stalled: input register, then
// framing and check logic into the result register.
// rst_n is asynchronous: no line open, running XOR and tail cleared.
// A stalled result holds; the input register keeps taking words while the
// result register is free or being emptied in the same cycle.
module nmea_sentence_framer_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [nsfc_pkg::TDATA_W-1:0] m_tdata    // checksum_ok, sentence_type, line_length
);
    import nsfc_pkg::*;

    logic               in_valid_reg;
    char_t              in_byte_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    char_t              xor_reg, xor_next;
    char_t              tail_reg [4];
    char_t              tail_next [4];
    type_str_t          type_reg, type_next;
    logic               out_valid_reg;
    logic               ok_reg, ok_next;
    logic [TYPE_W-1:0]  stype_reg, stype_next;
    logic [LEN_W-1:0]   len_reg;

    logic               advance;
    logic               is_dollar, overlong, drop, append, emit;
    logic [COUNT_W-1:0] count_app;
    char_t              body;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        is_dollar = (in_byte_reg == CHAR_DOLLAR);
        overlong  = (int'(count_reg) > LINE_LIMIT);
        drop      = (count_reg == '0) || (in_byte_reg == CHAR_CR);
        append    = !is_dollar && !overlong && !drop;
        emit      = append && (in_byte_reg == CHAR_LF);
        count_app = count_reg + 1'b1;

        count_next = count_reg;
        xor_next   = xor_reg;
        tail_next  = tail_reg;
        type_next  = type_reg;

        if (is_dollar)
        begin
            count_next = COUNT_W'(1);
            xor_next   = '0;
            tail_next  = '{default: '0};
        end
        else if (overlong)
        begin
            count_next = '0;
        end
        else if (append)
        begin
            xor_next     = xor_reg ^ in_byte_reg;
            tail_next[0] = tail_reg[1];
            tail_next[1] = tail_reg[2];
            tail_next[2] = tail_reg[3];
            tail_next[3] = in_byte_reg;
            if (count_reg == COUNT_W'(3))
            begin
                type_next[0] = in_byte_reg;
            end
            if (count_reg == COUNT_W'(4))
            begin
                type_next[1] = in_byte_reg;
            end
            if (count_reg == COUNT_W'(5))
            begin
                type_next[2] = in_byte_reg;
            end
            count_next = emit ? '0 : count_app;
        end

        body    = xor_next ^ tail_next[0] ^ tail_next[1] ^ tail_next[2] ^ tail_next[3];
        ok_next = (count_app >= COUNT_W'(5))
               && (tail_next[0] == CHAR_STAR)
               && (tail_next[1] == hex_char(body[7:4]))
               && (tail_next[2] == hex_char(body[3:0]));

        stype_next = TYPE_UNKNOWN;
        if (count_app >= COUNT_W'(6))
        begin
            for (int k = NUM_TYPES - 1; k >= 0; k--)
            begin
                if (type_next == KNOWN_TYPES[k])
                begin
                    stype_next = TYPE_W'(k);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            xor_reg       <= '0;
            tail_reg      <= '{default: '0};
            type_reg      <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                count_reg <= count_next;
                xor_reg   <= xor_next;
                tail_reg  <= tail_next;
                type_reg  <= type_next;
            end

            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && emit)
        begin
            ok_reg    <= ok_next;
            stype_reg <= stype_next;
            len_reg   <= count_app[LEN_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - OUT_W){1'b0}}, len_reg, stype_reg, ok_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= LINE_LIMIT + 1)
        else $error("line count beyond limit");

    a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (len_reg >= LEN_W'(2)))
        else $error("result line too short");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ok_reg) |-> (len_reg >= LEN_W'(5)))
        else $error("checksum pass on short line");

    a_type_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (stype_reg != TYPE_UNKNOWN)) |-> (len_reg >= LEN_W'(6)))
        else $error("known type on short line");

endmodule
